/* design/tsd_pkg.sv */
// shared constants and types for the triangle side descriptor
package tsd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int SIDE_W          = 25;
    localparam int SLOT_W          = 2;

    localparam logic [SLOT_W-1:0] SLOT_A = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_B = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_C = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        slot_t s0;
        slot_t s1;
        slot_t s2;
    } order_t;

endpackage

/* design/tsd_front.sv */
// squared side lengths, stable descending sort and clockwise swap, seven register stages
module tsd_front #(
    parameter int CW   = tsd_pkg::COORD_WIDTH_DEF,
    parameter int SQ_W = 2 * CW + 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic signed [CW-1:0]   pt [3][3],
    output logic                   out_vld,
    output tsd_pkg::order_t        ord,
    output logic [SQ_W-1:0]        sq_sorted [3]
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;

    logic [6:0] vld_reg;

    // stage 1: points and side differences
    logic signed [CW-1:0] p1_reg [3][3];
    logic signed [DW-1:0] d1_reg [3][3];
    // stage 2: squares
    logic signed [CW-1:0] p2_reg [3][3];
    logic [PW-2:0]        s2_reg [3][3];
    // stage 3: squared lengths
    logic signed [CW-1:0] p3_reg [3][3];
    logic [SQ_W-1:0]      q3_reg [3];
    // stage 4: sorted
    logic signed [CW-1:0] p4_reg [3][3];
    logic [SQ_W-1:0]      q4_reg [3];
    tsd_pkg::order_t      o4_reg;
    // stage 5: cross differences
    logic signed [DW-1:0] e5_reg [4];
    logic [SQ_W-1:0]      q5_reg [3];
    tsd_pkg::order_t      o5_reg;
    // stage 6: products
    logic signed [PW-1:0] m6_reg [2];
    logic [SQ_W-1:0]      q6_reg [3];
    tsd_pkg::order_t      o6_reg;
    // stage 7: swap
    logic [SQ_W-1:0]      q7_reg [3];
    tsd_pkg::order_t      o7_reg;

    logic signed [DW-1:0] d1_next [3][3];
    logic signed [PW-1:0] m2_next [3][3];
    logic [SQ_W-1:0]      q3_next [3];
    tsd_pkg::order_t      o4_next;
    logic [SQ_W-1:0]      q4_next [3];
    logic signed [CW-1:0] p4_next [3][3];
    logic signed [DW-1:0] e5_next [4];
    logic signed [PW-1:0] m6_next [2];
    logic                 swap;
    logic [1:0]           pos [3];
    logic                 bt [3][3];

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            d1_next[0][ax] = DW'(pt[1][ax]) - DW'(pt[2][ax]);
            d1_next[1][ax] = DW'(pt[0][ax]) - DW'(pt[2][ax]);
            d1_next[2][ax] = DW'(pt[0][ax]) - DW'(pt[1][ax]);
        end
        for (int s = 0; s < 3; s++)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                m2_next[s][ax] = d1_reg[s][ax] * d1_reg[s][ax];
            end
            q3_next[s] = SQ_W'(s2_reg[s][0]) + SQ_W'(s2_reg[s][1]) + SQ_W'(s2_reg[s][2]);
        end
    end

    // stable descending rank: k beats j when longer, or equal and lower slot
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                bt[k][j] = (q3_reg[k] > q3_reg[j]) || ((q3_reg[k] == q3_reg[j]) && (k < j));
            end
        end
        pos[0] = 2'(bt[1][0]) + 2'(bt[2][0]);
        pos[1] = 2'(bt[0][1]) + 2'(bt[2][1]);
        pos[2] = 2'(bt[0][2]) + 2'(bt[1][2]);
        o4_next = '{s0: tsd_pkg::SLOT_A, s1: tsd_pkg::SLOT_B, s2: tsd_pkg::SLOT_C};
        for (int k = 0; k < 3; k++)
        begin
            unique case (pos[k])
                2'd0:    o4_next.s0 = tsd_pkg::slot_t'(k);
                2'd1:    o4_next.s1 = tsd_pkg::slot_t'(k);
                default: o4_next.s2 = tsd_pkg::slot_t'(k);
            endcase
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            p4_next[0][ax] = p3_reg[o4_next.s0][ax];
            p4_next[1][ax] = p3_reg[o4_next.s1][ax];
            p4_next[2][ax] = p3_reg[o4_next.s2][ax];
        end
        q4_next[0] = q3_reg[o4_next.s0];
        q4_next[1] = q3_reg[o4_next.s1];
        q4_next[2] = q3_reg[o4_next.s2];
    end

    always_comb
    begin
        e5_next[0] = DW'(p4_reg[1][0]) - DW'(p4_reg[0][0]);
        e5_next[1] = DW'(p4_reg[2][1]) - DW'(p4_reg[0][1]);
        e5_next[2] = DW'(p4_reg[1][1]) - DW'(p4_reg[0][1]);
        e5_next[3] = DW'(p4_reg[2][0]) - DW'(p4_reg[0][0]);
        m6_next[0] = e5_reg[0] * e5_reg[1];
        m6_next[1] = e5_reg[2] * e5_reg[3];
        swap = m6_reg[0] > m6_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= pt;
            d1_reg <= d1_next;
            p2_reg <= p1_reg;
            for (int s = 0; s < 3; s++)
            begin
                for (int ax = 0; ax < 3; ax++)
                begin
                    s2_reg[s][ax] <= m2_next[s][ax][PW-2:0];
                end
            end
            p3_reg <= p2_reg;
            q3_reg <= q3_next;
            p4_reg <= p4_next;
            q4_reg <= q4_next;
            o4_reg <= o4_next;
            e5_reg <= e5_next;
            q5_reg <= q4_reg;
            o5_reg <= o4_reg;
            m6_reg <= m6_next;
            q6_reg <= q5_reg;
            o6_reg <= o5_reg;
            q7_reg[0] <= q6_reg[0];
            o7_reg.s0 <= o6_reg.s0;
            if (swap)
            begin
                q7_reg[1] <= q6_reg[2];
                q7_reg[2] <= q6_reg[1];
                o7_reg.s1 <= o6_reg.s2;
                o7_reg.s2 <= o6_reg.s1;
            end
            else
            begin
                q7_reg[1] <= q6_reg[1];
                q7_reg[2] <= q6_reg[2];
                o7_reg.s1 <= o6_reg.s1;
                o7_reg.s2 <= o6_reg.s2;
            end
        end
    end

    assign out_vld   = vld_reg[6];
    assign ord       = o7_reg;
    assign sq_sorted = q7_reg;

endmodule

/* design/tsd_sqrt.sv */
// pipelined floor square root, one result bit per stage, saturating
module tsd_sqrt #(
    parameter int SQ_W = 2 * tsd_pkg::COORD_WIDTH_DEF + 2
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [SQ_W-1:0]             val,
    output logic [tsd_pkg::SIDE_W-1:0]  root
);

    localparam int SW    = tsd_pkg::SIDE_W;
    localparam int NW    = 2 * SW;
    localparam int EXT_W = (SQ_W > NW) ? SQ_W : NW + 1;
    localparam int RW    = SW + 3;

    logic [EXT_W-1:0] ext;
    logic             sat_in;
    logic [NW-1:0]    rad_reg  [SW];
    logic [RW-1:0]    rem_reg  [SW];
    logic [SW-1:0]    root_reg [SW];
    logic             sat_reg  [SW];

    assign ext    = EXT_W'(val);
    assign sat_in = |ext[EXT_W-1:NW];

    for (genvar s = 0; s < SW; s++)
    begin : g_stage
        logic [NW-1:0] rad_in;
        logic [RW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic          sat_s;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;

        if (s == 0)
        begin : g_first
            assign rad_in  = ext[NW-1:0];
            assign rem_in  = '0;
            assign root_in = '0;
            assign sat_s   = sat_in;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign sat_s   = sat_reg[s-1];
        end

        assign rem_sh = {rem_in[RW-3:0], rad_in[NW-1:NW-2]};
        assign trial  = RW'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s] <= {rad_in[NW-3:0], 2'b00};
                sat_reg[s] <= sat_s;
                if (rem_sh >= trial)
                begin
                    rem_reg[s]  <= rem_sh - trial;
                    root_reg[s] <= {root_in[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s]  <= rem_sh;
                    root_reg[s] <= {root_in[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign root = sat_reg[SW-1] ? {SW{1'b1}} : root_reg[SW-1];

endmodule

/* design/triangle_side_descriptor_top.sv */
// top level of the triangle side descriptor
// Takes one triangle per clock and returns its vertex slots ordered by opposite side
// (longest first, ties to the lower slot, then clockwise) with floor side lengths.
// The pipeline has seven stages of differences, squares, sort and cross product,
// then a 25-stage square root with one result bit per stage. The whole pipeline
// freezes while a finished result is stalled; a new transfer is taken every cycle
// otherwise.
module triangle_side_descriptor_top #(
    parameter int COORD_WIDTH = tsd_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_WIDTH-1:0]      ax,
    input  logic signed [COORD_WIDTH-1:0]      ay,
    input  logic signed [COORD_WIDTH-1:0]      az,
    input  logic signed [COORD_WIDTH-1:0]      bx,
    input  logic signed [COORD_WIDTH-1:0]      by_coord,
    input  logic signed [COORD_WIDTH-1:0]      bz,
    input  logic signed [COORD_WIDTH-1:0]      cx,
    input  logic signed [COORD_WIDTH-1:0]      cy,
    input  logic signed [COORD_WIDTH-1:0]      cz,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tsd_pkg::SLOT_W-1:0]         first_slot,
    output logic [tsd_pkg::SLOT_W-1:0]         second_slot,
    output logic [tsd_pkg::SLOT_W-1:0]         third_slot,
    output logic [tsd_pkg::SIDE_W-1:0]         first_side,
    output logic [tsd_pkg::SIDE_W-1:0]         second_side,
    output logic [tsd_pkg::SIDE_W-1:0]         third_side
);

    localparam int SQ_W = 2 * COORD_WIDTH + 2;
    localparam int SW   = tsd_pkg::SIDE_W;

    logic                          en;
    logic signed [COORD_WIDTH-1:0] pt [3][3];
    logic                          f_vld;
    tsd_pkg::order_t               f_ord;
    logic [SQ_W-1:0]               f_sq [3];
    logic [SW-1:0]                 vld_reg;
    tsd_pkg::order_t               ord_reg [SW];
    logic [SW-1:0]                 side [3];

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    assign pt[0][0] = ax;
    assign pt[0][1] = ay;
    assign pt[0][2] = az;
    assign pt[1][0] = bx;
    assign pt[1][1] = by_coord;
    assign pt[1][2] = bz;
    assign pt[2][0] = cx;
    assign pt[2][1] = cy;
    assign pt[2][2] = cz;

    tsd_front #(
        .CW   (COORD_WIDTH),
        .SQ_W (SQ_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .pt        (pt),
        .out_vld   (f_vld),
        .ord       (f_ord),
        .sq_sorted (f_sq)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_root
        tsd_sqrt #(
            .SQ_W (SQ_W)
        ) u_sqrt (
            .clk  (clk),
            .en   (en),
            .val  (f_sq[k]),
            .root (side[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SW-2:0], f_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ord_reg[0] <= f_ord;
            for (int s = 1; s < SW; s++)
            begin
                ord_reg[s] <= ord_reg[s-1];
            end
        end
    end

    assign out_valid   = vld_reg[SW-1];
    assign first_slot  = ord_reg[SW-1].s0;
    assign second_slot = ord_reg[SW-1].s1;
    assign third_slot  = ord_reg[SW-1].s2;
    assign first_side  = side[0];
    assign second_side = side[1];
    assign third_side  = side[2];

    // slots form a permutation of the three inputs
    a_slots_perm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_slot != second_slot) && (first_slot != third_slot)
                   && (second_slot != third_slot) && (first_slot != 2'd3)
                   && (second_slot != 2'd3) && (third_slot != 2'd3))
        else $error("result slots are not a permutation");

    // the first side is the longest
    a_longest_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_side >= second_side) && (first_side >= third_side))
        else $error("first side is not the longest");

    // a stalled result freezes the whole pipeline
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg) && $stable(f_vld))
        else $error("pipeline moved under stall");

endmodule
